// ===== rtl/core/i2da_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2da_pkg
// types, codes and helpers for the integer to decimal ascii core
// ----------------------------------------------------------------------------
package i2da_pkg;

  localparam int DIGITS_MAX = 5;
  localparam int CHARS_MAX  = DIGITS_MAX + 1;

  localparam logic [1:0] CMD_U8  = 2'd0;
  localparam logic [1:0] CMD_U16 = 2'd1;
  localparam logic [1:0] CMD_S16 = 2'd2;

  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_MINUS = 8'h2d;
  localparam logic [3:0]  RADIX      = 4'd10;
  localparam logic [15:0] RECIP_10   = 16'd52429;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] ascii_char;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic                        neg;
    logic [15:0]                 q;
    logic [DIGITS_MAX-2:0][3:0]  dig;
  } stg_t;

  // exact x / 10 for any 16-bit x
  function automatic logic [15:0] div10(input logic [15:0] x);
    logic [31:0] prod;
    prod = x * RECIP_10;
    return 16'(prod[31:19]);
  endfunction

endpackage

// ===== rtl/core/integer_to_decimal_ascii_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_core
// converts a 16-bit value to decimal ascii text, one character per item out
// ----------------------------------------------------------------------------
// throughput: a new number enters every cycle into the digit pipeline unless
//   a stall holds it; the single output serializer sends one character per
//   cycle while out_ready is high, 1 to 6 characters for each number
// reset: rst_n synchronous active low clears all valid bits; no clearing pass
module integer_to_decimal_ascii_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2da_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output i2da_pkg::out_item_t out_item
);
  import i2da_pkg::*;

  localparam int NSTG = DIGITS_MAX;

  // stage 0 sign and magnitude, divide stages 1..4, pack stage 5, serializer load 6
  logic [NSTG+1:0]    adv;
  logic [NSTG-1:0]    stg_v_r;
  stg_t [NSTG-1:0]    stg_r;
  stg_t [NSTG-1:0]    stg_nxt;
  logic               in_take;

  logic               pk_v_r;
  logic [8*CHARS_MAX-1:0] pk_chars_r;
  logic [8*CHARS_MAX-1:0] pk_chars_nxt;
  logic [2:0]         pk_cnt_r;
  logic [2:0]         pk_cnt_nxt;

  logic               ser_valid_r;
  logic [8*CHARS_MAX-1:0] ser_chars_r;
  logic [2:0]         ser_cnt_r;

  logic [15:0]        mag;
  logic               neg;
  logic [15:0]        quot;
  logic [19:0]        digs;
  logic [19:0]        digs_sh;
  logic [2:0]         nd;
  logic [4:0]         shamt;
  logic [8*DIGITS_MAX-1:0] dchr;

  assign in_take = in_item.command == CMD_U8 || in_item.command == CMD_U16 ||
                   in_item.command == CMD_S16;

  // ready chain
  always_comb begin
    adv[NSTG+1] = !ser_valid_r || (out_ready && ser_cnt_r == 3'd1);
    adv[NSTG]   = !pk_v_r || adv[NSTG+1];
    for (int k = NSTG - 1; k >= 0; k--) begin
      adv[k] = !stg_v_r[k] || adv[k+1];
    end
  end
  assign in_ready = adv[0];

  // stage 0: magnitude and sign; stages 1..4: one digit each
  always_comb begin
    neg = 1'b0;
    case (in_item.command)
      CMD_U8:  mag = {8'h00, in_item.value[7:0]};
      CMD_U16: mag = in_item.value;
      CMD_S16: begin
        neg = in_item.value[15];
        mag = in_item.value[15] ? 16'(~in_item.value + 16'd1) : in_item.value;
      end
      default: mag = in_item.value;
    endcase
    stg_nxt[0].neg = neg;
    stg_nxt[0].q   = mag;
    stg_nxt[0].dig = '0;
    for (int k = 1; k < NSTG; k++) begin
      stg_nxt[k]          = stg_r[k-1];
      quot                = div10(stg_r[k-1].q);
      stg_nxt[k].q        = quot;
      stg_nxt[k].dig[k-1] = 4'(stg_r[k-1].q - 16'(quot * RADIX));
    end
  end

  // pack stage: suppress leading zeros, add sign, left align
  always_comb begin
    digs = {stg_r[NSTG-1].q[3:0], stg_r[NSTG-1].dig[3], stg_r[NSTG-1].dig[2],
            stg_r[NSTG-1].dig[1], stg_r[NSTG-1].dig[0]};
    if (digs[19:16] != 4'd0)      nd = 3'd5;
    else if (digs[15:12] != 4'd0) nd = 3'd4;
    else if (digs[11:8] != 4'd0)  nd = 3'd3;
    else if (digs[7:4] != 4'd0)   nd = 3'd2;
    else                          nd = 3'd1;
    shamt   = 5'(3'd5 - nd) << 2;
    digs_sh = digs << shamt;
    for (int i = 0; i < DIGITS_MAX; i++) begin
      dchr[i*8 +: 8] = CHAR_ZERO + {4'h0, digs_sh[i*4 +: 4]};
    end
    if (stg_r[NSTG-1].neg) begin
      pk_chars_nxt = {CHAR_MINUS, dchr};
      pk_cnt_nxt   = nd + 3'd1;
    end else begin
      pk_chars_nxt = {dchr, 8'h00};
      pk_cnt_nxt   = nd;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r     <= '0;
      pk_v_r      <= 1'b0;
      ser_valid_r <= 1'b0;
    end else begin
      if (adv[0]) begin
        stg_v_r[0] <= in_valid && in_take;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) begin
          stg_v_r[k] <= stg_v_r[k-1];
        end
      end
      if (adv[NSTG]) begin
        pk_v_r <= stg_v_r[NSTG-1];
      end
      if (adv[NSTG+1]) begin
        ser_valid_r <= pk_v_r;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (adv[k]) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
    if (adv[NSTG]) begin
      pk_chars_r <= pk_chars_nxt;
      pk_cnt_r   <= pk_cnt_nxt;
    end
    if (adv[NSTG+1]) begin
      ser_chars_r <= pk_chars_r;
      ser_cnt_r   <= pk_cnt_r;
    end else if (ser_valid_r && out_ready) begin
      ser_chars_r <= ser_chars_r << 8;
      ser_cnt_r   <= ser_cnt_r - 3'd1;
    end
  end

  assign out_valid           = ser_valid_r;
  assign out_item.ascii_char = ser_chars_r[8*CHARS_MAX-1 -: 8];
  assign out_item.last       = ser_cnt_r == 3'd1;

  // checks
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    ser_valid_r |-> (ser_cnt_r >= 3'd1 && ser_cnt_r <= 3'(CHARS_MAX)))
    else $error("character count out of range");

  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_item.last) |=> out_valid)
    else $error("number text broken before last character");

  a_char_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.ascii_char == CHAR_MINUS ||
                   (out_item.ascii_char >= CHAR_ZERO &&
                    out_item.ascii_char <= CHAR_ZERO + 8'd9)))
    else $error("bad character code");

  a_top_digit: assert property (@(posedge clk) disable iff (!rst_n)
    stg_v_r[NSTG-1] |-> stg_r[NSTG-1].q < 16'(RADIX))
    else $error("top quotient is not a single digit");

  a_drop_rsvd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_take) |=> !stg_v_r[0])
    else $error("unused command entered the pipeline");

endmodule

// ===== bench/i2da_text_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2da_text_checker
// watches both channels of the integer to decimal ascii core, works out the
// decimal text of every accepted number and compares each character sent
// ----------------------------------------------------------------------------
module i2da_text_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  i2da_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  i2da_pkg::out_item_t out_item,
  output int                  mismatch_count,
  output int                  chars_pending
);
  import i2da_pkg::*;

  out_item_t expected_text [$];

  initial begin
    mismatch_count = 0;
    chars_pending  = 0;
  end

  function automatic void predict_text(input in_item_t item);
    int unsigned mag;
    int unsigned digits [DIGITS_MAX];
    out_item_t   text [$];
    bit          started;
    started = 1'b0;
    case (item.command)
      CMD_U8:  mag = item.value[7:0];
      CMD_U16: mag = item.value;
      CMD_S16: begin
        mag = item.value;
        if (item.value[15]) begin
          text.push_back('{ascii_char: CHAR_MINUS, last: 1'b0});
          mag = 32'h10000 - item.value;
        end
      end
      default: return;
    endcase
    for (int i = 0; i < DIGITS_MAX; i++) begin
      digits[i] = mag % RADIX;
      mag = mag / RADIX;
    end
    for (int i = DIGITS_MAX - 1; i >= 0; i--) begin
      if (digits[i] != 0 || i == 0) started = 1'b1;
      if (started) text.push_back('{ascii_char: CHAR_ZERO + 8'(digits[i]), last: 1'b0});
    end
    text[text.size() - 1].last = 1'b1;
    foreach (text[k]) expected_text.push_back(text[k]);
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      expected_text.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_text.size() == 0) begin
          $error("unexpected character %h last %b", out_item.ascii_char, out_item.last);
          mismatch_count++;
        end else begin
          want = expected_text.pop_front();
          if (out_item.ascii_char !== want.ascii_char) begin
            $error("ascii_char expected %h got %h", want.ascii_char, out_item.ascii_char);
            mismatch_count++;
          end
          if (out_item.last !== want.last) begin
            $error("last expected %b got %b", want.last, out_item.last);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) predict_text(in_item);
    end
    chars_pending = expected_text.size();
  end

endmodule

// ===== bench/tb_integer_to_decimal_ascii_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_decimal_ascii_core
// drives numbers in all three formats plus the unused command, first the
// corner values and then random ones, with random gaps on both channels;
// a separate checker predicts and compares every character
// ----------------------------------------------------------------------------
module tb_integer_to_decimal_ascii_core;
  import i2da_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 180;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         TEN_POW [5]  = '{1, 10, 100, 1000, 10000};

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  int        mismatch_count;
  int        chars_pending;
  bit        calm      = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  integer_to_decimal_ascii_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  i2da_text_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_item       (out_item),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending)
  );

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 13);
  end

  task automatic send_number(input logic [1:0] command, input logic [15:0] value);
    if (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_item.command <= command;
    in_item.value   <= value;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int          numbers_sent;
    logic [1:0]  cmd;
    logic [15:0] val;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_number(CMD_U8, 16'd0);
    send_number(CMD_U8, 16'd9);
    send_number(CMD_U8, 16'd10);
    send_number(CMD_U8, 16'd99);
    send_number(CMD_U8, 16'd100);
    send_number(CMD_U8, 16'd255);
    send_number(CMD_U8, 16'hab00);
    send_number(CMD_U8, 16'hffff);
    send_number(CMD_U16, 16'd0);
    send_number(CMD_U16, 16'd1);
    send_number(CMD_U16, 16'd100);
    send_number(CMD_U16, 16'd9999);
    send_number(CMD_U16, 16'd10000);
    send_number(CMD_U16, 16'd65535);
    send_number(CMD_S16, 16'd0);
    send_number(CMD_S16, 16'd1);
    send_number(CMD_S16, 16'd32767);
    send_number(CMD_S16, 16'h8000);
    send_number(CMD_S16, 16'h8001);
    send_number(CMD_S16, 16'hffff);
    send_number(CMD_S16, 16'hfff6);
    send_number(CMD_UNUSED, 16'd0);
    send_number(CMD_UNUSED, 16'hffff);
    send_number(CMD_U16, 16'd7);

    numbers_sent = 0;
    while (numbers_sent < RANDOM_ITEMS) begin
      calm = (numbers_sent >= 90 && numbers_sent < 150);
      cmd  = ($urandom_range(99) < 8) ? CMD_UNUSED : 2'($urandom_range(2));
      case ($urandom_range(3))
        0:       val = 16'($urandom);
        1:       val = 16'($urandom_range(20));
        2:       val = 16'(TEN_POW[$urandom_range(4)] + $urandom_range(2) - 1);
        default: val = {($urandom_range(1) != 0) ? 8'hff : 8'h80, 8'($urandom)};
      endcase
      send_number(cmd, val);
      if (cmd != CMD_UNUSED) numbers_sent++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_integer_to_decimal_ascii_core: clean");
    end else begin
      $display("tb_integer_to_decimal_ascii_core: errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_integer_to_decimal_ascii_core: errors");
    $finish;
  end

endmodule
